/* rtl/line_ring_buffer_unit_macros.svh */
// assertion macros for the line ring buffer unit
`ifndef LINE_RING_BUFFER_UNIT_MACROS_SVH
`define LINE_RING_BUFFER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LRB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LRB_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LRB_ASSERT(label, clk, rst, prop, msg)
`define LRB_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/lrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg
// types and constants shared by the line ring buffer unit
// ----------------------------------------------------------------------------
package lrb_pkg;
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_END    = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;
   localparam logic [7:0] NEWLINE   = 8'd10;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic       rejected;
      logic [6:0] lines_held;
   } rsp_type;
endpackage

/* rtl/line_ring_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_ring_buffer_unit
// keeps the newest lines of text in a circular store and returns them one byte per read
// ----------------------------------------------------------------------------
// append, end, no-op or a read with no lines held go from the queue through idle
//   and exec; a read of a stored line goes through the table reads and the byte
//   read; each dropped line first adds a drop and a drop wait step; the engine
//   takes one command at a time, set by its sequencer and the single port of each ram
// the receiver cannot stall; rsp_strobe marks each result for one cycle
// reset clears all pointers and counts but the latched read line start; store contents are left as they are
module line_ring_buffer_unit #(
   parameter int MAX_LINES      = 64,
   parameter int BYTES_PER_LINE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lrb_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lrb_pkg::rsp_type rsp_data
);
   logic             q_valid, q_pop;
   lrb_pkg::req_type q_data;

   lrb_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

   lrb_engine #(.MAX_LINES(MAX_LINES), .BYTES_PER_LINE(BYTES_PER_LINE)) u_engine (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data));
endmodule

/* rtl/lrb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module lrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // registered read returns the old word on a write
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* rtl/lrb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_front
// accepts commands and holds them in a two entry queue for the engine
// ----------------------------------------------------------------------------
module lrb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lrb_pkg::req_type req_data,
   output logic             busy,
   output logic             q_valid,
   output lrb_pkg::req_type q_data,
   input  logic             q_pop
);
   lrb_pkg::req_type ent_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;

   assign busy    = cnt_ff[1];
   assign push    = start && !busy;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data  = ent_ff[rd_ff];

   // queue pointers
   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
      rd_in  = rd_ff ^ (q_pop && q_valid);
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) ent_ff[wr_ff] <= req_data;
   end

   `include "line_ring_buffer_unit_macros.svh"
   `LRB_ASSERT(a_cnt_max, clock, reset, cnt_ff != 2'd3, "queue count overflow")
   `LRB_ASSERT(a_full_busy, clock, reset, (cnt_ff == 2'd2) |-> busy, "full queue not busy")
   `LRB_ASSERT(a_push_cnt, clock, reset, (push && !q_pop) |=> cnt_ff != 2'd0, "lost push")
endmodule

/* rtl/lrb_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_engine
// carries out queued commands against the byte store and line table
// ----------------------------------------------------------------------------
module lrb_engine #(
   parameter int MAX_LINES      = 64,
   parameter int BYTES_PER_LINE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  lrb_pkg::req_type q_data,
   output logic             q_pop,
   output logic             rsp_strobe,
   output lrb_pkg::rsp_type rsp_data
);
   localparam int STORE = MAX_LINES * BYTES_PER_LINE;
   localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int PW    = AW + 1;
   localparam int SW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int LW    = $clog2(MAX_LINES + 1);
   localparam logic [PW:0] LAP = (PW + 1)'(2 * STORE);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DROP  = 3'd1; // reading next line start for drop
   localparam logic [2:0] S_DROPW = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_RD    = 3'd4; // table read for read begin / finish
   localparam logic [2:0] S_RDW   = 3'd5;
   localparam logic [2:0] S_RDB   = 3'd6; // byte read
   localparam logic [2:0] S_RDBW  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] wpos_ff, wpos_in, opos_ff, opos_in, ostart_ff, ostart_in;
   logic [PW-1:0] rpos_ff, rpos_in, beg_ff, beg_in;
   logic [SW-1:0] oslot_ff, oslot_in;
   logic [LW-1:0] total_ff, total_in, rline_ff, rline_in;
   logic          open_ff, open_in, phase_ff, phase_in;
   logic          strobe_in;
   lrb_pkg::rsp_type rsp_ff, rsp_in;

   logic          b_we, t_we;
   logic [AW-1:0] b_addr;
   logic [7:0]    b_q;
   logic [SW-1:0] t_addr;
   logic [PW-1:0] t_wd, t_q;

   // helpers
   function automatic logic [PW-1:0] lap_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= LAP) s = s - LAP;
      return s[PW-1:0];
   endfunction
   function automatic logic [PW-1:0] lap_dist(input logic [PW-1:0] f, input logic [PW-1:0] t);
      logic [PW:0] s;
      s = (t >= f) ? {1'b0, t} - {1'b0, f} : {1'b0, t} + LAP - {1'b0, f};
      return s[PW-1:0];
   endfunction
   function automatic logic [AW-1:0] sidx(input logic [PW-1:0] p);
      logic [PW-1:0] q;
      q = (p >= PW'(STORE)) ? p - PW'(STORE) : p;
      return q[AW-1:0];
   endfunction
   function automatic logic [SW-1:0] slot(input logic [SW-1:0] o, input logic [LW-1:0] k);
      logic [LW:0] s;
      s = (LW + 1)'(o) + (LW + 1)'(k);
      if (s >= (LW + 1)'(MAX_LINES)) s = s - (LW + 1)'(MAX_LINES);
      return s[SW-1:0];
   endfunction

   logic [PW-1:0] used, tail_end;
   logic          op_app, op_end, op_rd;
   assign used     = lap_dist(opos_ff, wpos_ff);
   assign tail_end = open_ff ? ostart_ff : wpos_ff;
   assign op_app   = q_data.opcode == lrb_pkg::OP_APPEND;
   assign op_end   = q_data.opcode == lrb_pkg::OP_END;
   assign op_rd    = q_data.opcode == lrb_pkg::OP_READ;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      wpos_in   = wpos_ff;  opos_in = opos_ff;  ostart_in = ostart_ff;
      rpos_in   = rpos_ff;  beg_in  = beg_ff;   oslot_in  = oslot_ff;
      total_in  = total_ff; rline_in = rline_ff; open_in = open_ff;
      phase_in  = phase_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      q_pop     = 1'b0;
      b_we = 1'b0; t_we = 1'b0;
      b_addr = sidx(wpos_ff);
      t_addr = oslot_ff;
      t_wd   = tail_end;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (op_rd) begin
                  if (total_ff == '0) begin
                     rline_in = '0; rpos_in = '0; state_in = S_EXEC;
                  end else begin
                     if (rline_ff >= total_ff) begin
                        rline_in = '0; rpos_in = '0;
                     end
                     phase_in = 1'b0;
                     state_in = S_RD;
                  end
               end else if ((op_app && !open_ff && total_ff >= LW'(MAX_LINES)) ||
                            (op_end && total_ff >= LW'(MAX_LINES)) ||
                            (op_app && used >= PW'(STORE) && total_ff != '0)) begin
                  state_in = S_DROP;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_DROP: begin
            t_addr   = slot(oslot_ff, LW'(1));
            state_in = S_DROPW;
         end
         S_DROPW: begin
            opos_in  = (total_ff > LW'(1)) ? t_q : tail_end;
            oslot_in = slot(oslot_ff, LW'(1));
            total_in = total_ff - LW'(1);
            state_in = S_IDLE;
         end
         S_RD: begin
            t_addr   = phase_ff ? slot(oslot_ff, rline_ff + LW'(1)) : slot(oslot_ff, rline_ff);
            state_in = S_RDW;
         end
         S_RDW: begin
            if (!phase_ff) begin
               beg_in = t_q;
               if (rline_ff + LW'(1) < total_ff) begin
                  phase_in = 1'b1; state_in = S_RD;
               end else begin
                  state_in = S_RDB;
               end
            end else begin
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            // keep the next line start on the table output for the length check
            t_addr   = slot(oslot_ff, rline_ff + LW'(1));
            b_addr   = sidx(lap_add(beg_ff, rpos_ff));
            state_in = S_RDBW;
         end
         S_RDBW: begin
            q_pop = 1'b1; strobe_in = 1'b1; state_in = S_IDLE;
            rsp_in = '0;
            rsp_in.out_valid = 1'b1;
            rsp_in.lines_held = 7'(total_ff);
            if (rpos_ff < lap_dist(beg_ff, phase_ff ? t_q : tail_end)) begin
               rsp_in.out_byte = b_q;
               rpos_in = rpos_ff + PW'(1);
            end else begin
               rsp_in.out_byte = lrb_pkg::NEWLINE;
               rpos_in = '0;
               if (rline_ff + LW'(1) >= total_ff) begin
                  rsp_in.out_last = 1'b1; rline_in = '0;
               end else begin
                  rline_in = rline_ff + LW'(1);
               end
            end
         end
         S_EXEC: begin
            q_pop = 1'b1; strobe_in = 1'b1; state_in = S_IDLE;
            rsp_in = '0;
            rsp_in.lines_held = 7'(total_ff);
            if (op_app) begin
               if (!open_ff) begin
                  open_in = 1'b1; ostart_in = wpos_ff;
               end
               if (used >= PW'(STORE)) begin
                  rsp_in.rejected = 1'b1;
               end else begin
                  b_we    = 1'b1;
                  wpos_in = lap_add(wpos_ff, PW'(1));
               end
            end else if (op_end) begin
               t_we   = 1'b1;
               t_addr = slot(oslot_ff, total_ff);
               if (total_ff == '0) opos_in = tail_end;
               total_in = total_ff + LW'(1);
               open_in  = 1'b0;
               rsp_in.lines_held = 7'(total_ff + LW'(1));
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wpos_ff <= '0; opos_ff <= '0; ostart_ff <= '0; rpos_ff <= '0;
         oslot_ff <= '0; total_ff <= '0; rline_ff <= '0; open_ff <= 1'b0;
         phase_ff <= 1'b0; rsp_strobe <= 1'b0; rsp_ff <= '0;
      end else begin
         state_ff <= state_in;
         wpos_ff <= wpos_in; opos_ff <= opos_in; ostart_ff <= ostart_in;
         rpos_ff <= rpos_in; oslot_ff <= oslot_in; total_ff <= total_in;
         rline_ff <= rline_in; open_ff <= open_in; phase_ff <= phase_in;
         rsp_strobe <= strobe_in; rsp_ff <= rsp_in;
      end
      beg_ff <= beg_in;
   end
   assign rsp_data = rsp_ff;

   lrb_ram #(.WIDTH(8), .DEPTH(STORE)) u_bytes (
      .clock(clock), .wr_en(b_we), .addr(b_addr), .wr_data(q_data.char_in), .rd_data(b_q));
   lrb_ram #(.WIDTH(PW), .DEPTH(MAX_LINES)) u_starts (
      .clock(clock), .wr_en(t_we), .addr(t_addr), .wr_data(t_wd), .rd_data(t_q));

   `include "line_ring_buffer_unit_macros.svh"
   `LRB_ASSERT(a_total, clock, reset, total_ff <= LW'(MAX_LINES), "line count overflow")
   `LRB_ASSERT(a_used, clock, reset, used <= PW'(STORE), "byte count overflow")
   `LRB_ASSERT(a_pop, clock, reset, q_pop |=> rsp_strobe, "pop without result")
endmodule
